### rtl/core/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define FFD_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled while reset is asserted
`define FFD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### rtl/core/ffd_pkg.sv
// shared types and constants of the free-fall detector
`default_nettype none

package ffd_pkg;

  localparam int SAMPLE_WIDTH = 16;
  localparam int COUNT_WIDTH  = 32;
  localparam int CFG_WIDTH    = 15;
  localparam int MIN_WIDTH    = 16;
  localparam int FALL_WIDTH   = 16;
  localparam int OUT_WIDTH    = 32;
  localparam int CMP_WIDTH    = (SAMPLE_WIDTH > CFG_WIDTH) ? SAMPLE_WIDTH : CFG_WIDTH;
  localparam int APB_DATA_W   = 32;
  localparam int APB_ADDR_W   = 4;

  localparam logic signed [CFG_WIDTH-1:0] WINDOW_LOW_RST  = -15'sd1638;
  localparam logic signed [CFG_WIDTH-1:0] WINDOW_HIGH_RST = 15'sd1638;
  localparam logic [MIN_WIDTH-1:0]        MIN_RUN_RST     = 16'd60;

  typedef enum logic [1:0] {
    REG_WINDOW_LOW  = 2'd0,
    REG_WINDOW_HIGH = 2'd1,
    REG_MIN_RUN     = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic signed [CFG_WIDTH-1:0] window_low;
    logic signed [CFG_WIDTH-1:0] window_high;
    logic [MIN_WIDTH-1:0]        min_run;
  } cfg_t;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] x;
    logic signed [SAMPLE_WIDTH-1:0] y;
    logic signed [SAMPLE_WIDTH-1:0] z;
  } sample_t;

  typedef struct packed {
    logic [FALL_WIDTH-1:0] fall_index;
    logic [OUT_WIDTH-1:0]  run_length;
    logic [OUT_WIDTH-1:0]  start_sample;
    sample_t               echo;
  } record_t;

endpackage

`default_nettype wire

### rtl/core/ffd_apb_regs.sv
// apb configuration registers: window bounds and minimum run length
`default_nettype none

module ffd_apb_regs (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [ffd_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [ffd_pkg::APB_DATA_W-1:0] pwdata,
  output logic      [ffd_pkg::APB_DATA_W-1:0] prdata,
  output logic                               pready,
  output ffd_pkg::cfg_t                      cfg_o
);

  ffd_pkg::cfg_t     cfg_q, cfg_d;
  ffd_pkg::reg_idx_e idx;
  logic              wr_en;

  assign idx    = ffd_pkg::reg_idx_e'(paddr[ffd_pkg::APB_ADDR_W-1:2]);
  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        ffd_pkg::REG_WINDOW_LOW:  cfg_d.window_low  = pwdata[ffd_pkg::CFG_WIDTH-1:0];
        ffd_pkg::REG_WINDOW_HIGH: cfg_d.window_high = pwdata[ffd_pkg::CFG_WIDTH-1:0];
        ffd_pkg::REG_MIN_RUN:     cfg_d.min_run     = pwdata[ffd_pkg::MIN_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.window_low  <= ffd_pkg::WINDOW_LOW_RST;
      cfg_q.window_high <= ffd_pkg::WINDOW_HIGH_RST;
      cfg_q.min_run     <= ffd_pkg::MIN_RUN_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    case (idx)
      ffd_pkg::REG_WINDOW_LOW:  prdata = ffd_pkg::APB_DATA_W'(cfg_q.window_low);
      ffd_pkg::REG_WINDOW_HIGH: prdata = ffd_pkg::APB_DATA_W'(cfg_q.window_high);
      ffd_pkg::REG_MIN_RUN:     prdata = ffd_pkg::APB_DATA_W'(cfg_q.min_run);
      default:                  prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

### rtl/core/ffd_detect.sv
// window test, run and sample counters, fall numbering and record build
`default_nettype none

module ffd_detect (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             step_i,
  input  wire ffd_pkg::sample_t sample_i,
  input  wire ffd_pkg::cfg_t    cfg_i,
  output logic                  flag_o,
  output ffd_pkg::record_t      record_o
);

  localparam logic [ffd_pkg::COUNT_WIDTH-1:0] CountMax = '1;
  localparam logic [ffd_pkg::FALL_WIDTH-1:0]  FallMax  = '1;

  logic [ffd_pkg::COUNT_WIDTH-1:0] elapsed_q, elapsed_d;
  logic [ffd_pkg::COUNT_WIDTH-1:0] run_q, run_d;
  logic [ffd_pkg::FALL_WIDTH-1:0]  fall_q, fall_d;
  logic                            prev_flag_q;
  logic [ffd_pkg::COUNT_WIDTH-1:0] start;

  logic signed [ffd_pkg::CMP_WIDTH-1:0] lo, hi, ax, ay, az;
  logic                                 in_win;

  assign lo = ffd_pkg::CMP_WIDTH'(cfg_i.window_low);
  assign hi = ffd_pkg::CMP_WIDTH'(cfg_i.window_high);
  assign ax = ffd_pkg::CMP_WIDTH'(sample_i.x);
  assign ay = ffd_pkg::CMP_WIDTH'(sample_i.y);
  assign az = ffd_pkg::CMP_WIDTH'(sample_i.z);

  assign in_win = (ax >= lo) && (ax <= hi) && (ay >= lo) && (ay <= hi) &&
                  (az >= lo) && (az <= hi);

  always_comb begin
    elapsed_d = (elapsed_q == CountMax) ? elapsed_q : elapsed_q + 1'b1;
    if (!in_win) begin
      run_d = '0;
    end else begin
      run_d = (run_q == CountMax) ? run_q : run_q + 1'b1;
    end
    // zero minimum behaves like one since an in-window run is at least one
    flag_o = in_win && (run_d >= ffd_pkg::COUNT_WIDTH'(cfg_i.min_run));
    fall_d = fall_q;
    if (flag_o && !prev_flag_q && (fall_q != FallMax)) begin
      fall_d = fall_q + 1'b1;
    end
    start = (elapsed_d >= run_d) ? elapsed_d - run_d : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elapsed_q   <= '0;
      run_q       <= '0;
      fall_q      <= '0;
      prev_flag_q <= 1'b0;
    end else if (step_i) begin
      elapsed_q   <= elapsed_d;
      run_q       <= run_d;
      fall_q      <= fall_d;
      prev_flag_q <= flag_o;
    end
  end

  assign record_o.fall_index   = fall_d;
  assign record_o.run_length   = ffd_pkg::OUT_WIDTH'(run_d);
  assign record_o.start_sample = ffd_pkg::OUT_WIDTH'(start);
  assign record_o.echo         = sample_i;

endmodule

`default_nettype wire

### rtl/core/free_fall_detector.sv
// Free-fall detector top level
//
// Input channel: one three-axis sample (accel_x/y/z, signed Q1.14) per request,
// taken when in_valid_i is high and in_stall_o is low.
// Output channel: one record per flagged sample (fall number, run length,
// start sample, echoed axes), taken when out_valid_o is high and out_stall_i
// is low. Samples that are not flagged produce no record.
// Configuration: APB registers window_low (0x0), window_high (0x4) and
// min_run_samples (0x8); write them only while the block is idle.
// Path: an accepted sample is evaluated from the input register once the
// output register is free, and a flagged sample's record lands there.
// Throughput: one sample per cycle while the output register is free,
// limited by the single evaluation stage between the input and output registers.
// Stall: while the output register holds an untaken record, the input
// register keeps its sample and in_stall_o rises once that register is full.
// Reset clears all counters and valid flags and loads default window and min_run.
`default_nettype none

module free_fall_detector (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 in_valid_i,
  output logic                                      in_stall_o,
  input  wire logic signed [ffd_pkg::SAMPLE_WIDTH-1:0] accel_x_i,
  input  wire logic signed [ffd_pkg::SAMPLE_WIDTH-1:0] accel_y_i,
  input  wire logic signed [ffd_pkg::SAMPLE_WIDTH-1:0] accel_z_i,
  output logic                                      out_valid_o,
  input  wire logic                                 out_stall_i,
  output logic [ffd_pkg::FALL_WIDTH-1:0]            fall_index_o,
  output logic [ffd_pkg::OUT_WIDTH-1:0]             run_length_o,
  output logic [ffd_pkg::OUT_WIDTH-1:0]             start_sample_o,
  output logic signed [ffd_pkg::SAMPLE_WIDTH-1:0]   echo_x_o,
  output logic signed [ffd_pkg::SAMPLE_WIDTH-1:0]   echo_y_o,
  output logic signed [ffd_pkg::SAMPLE_WIDTH-1:0]   echo_z_o,
  input  wire logic                                 psel,
  input  wire logic                                 penable,
  input  wire logic                                 pwrite,
  input  wire logic [ffd_pkg::APB_ADDR_W-1:0]       paddr,
  input  wire logic [ffd_pkg::APB_DATA_W-1:0]       pwdata,
  output logic      [ffd_pkg::APB_DATA_W-1:0]       prdata,
  output logic                                      pready
);

  ffd_pkg::cfg_t    cfg;
  ffd_pkg::sample_t in_q;
  ffd_pkg::record_t rec, out_q;
  logic             in_valid_q;
  logic             out_valid_q;
  logic             out_free;
  logic             step;
  logic             flag;
  logic             in_take;

  ffd_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  ffd_detect u_detect (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .sample_i (in_q),
    .cfg_i    (cfg),
    .flag_o   (flag),
    .record_o (rec)
  );

  // output register is free when empty or being drained this cycle
  assign out_free   = !out_valid_q || !out_stall_i;
  assign step       = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (step) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q.x <= accel_x_i;
      in_q.y <= accel_y_i;
      in_q.z <= accel_z_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= step && flag;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && flag) begin
      out_q <= rec;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign fall_index_o   = out_q.fall_index;
  assign run_length_o   = out_q.run_length;
  assign start_sample_o = out_q.start_sample;
  assign echo_x_o       = out_q.echo.x;
  assign echo_y_o       = out_q.echo.y;
  assign echo_z_o       = out_q.echo.z;

endmodule

`default_nettype wire

### rtl/core/ffd_checker.sv
// port-level assertions for the free-fall detector and their bind
`default_nettype none
`include "assert_macros.svh"

module ffd_checker (
  input wire logic                                 clk_i,
  input wire logic                                 rst_ni,
  input wire logic                                 out_valid_o,
  input wire logic                                 out_stall_i,
  input wire logic [ffd_pkg::FALL_WIDTH-1:0]       fall_index_o,
  input wire logic [ffd_pkg::OUT_WIDTH-1:0]        run_length_o,
  input wire logic [ffd_pkg::OUT_WIDTH-1:0]        start_sample_o,
  input wire logic signed [ffd_pkg::SAMPLE_WIDTH-1:0] echo_x_o,
  input wire logic signed [ffd_pkg::SAMPLE_WIDTH-1:0] echo_y_o,
  input wire logic signed [ffd_pkg::SAMPLE_WIDTH-1:0] echo_z_o
);

  localparam int SumW  = ffd_pkg::OUT_WIDTH + 1;
  localparam int HeldW = ffd_pkg::FALL_WIDTH + 2 * ffd_pkg::OUT_WIDTH +
                         3 * ffd_pkg::SAMPLE_WIDTH;

  logic [HeldW-1:0] held_rec;
  logic [SumW-1:0]  span_sum;

  assign held_rec = {fall_index_o, run_length_o, start_sample_o, echo_x_o, echo_y_o, echo_z_o};
  assign span_sum = SumW'(start_sample_o) + SumW'(run_length_o);

  // a held record keeps all of its fields
  `FFD_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(held_rec))

  // every record belongs to a numbered fall
  `FFD_ASSERT_IMPLY(a_fall_nonzero, clk_i, rst_ni, out_valid_o, fall_index_o != '0)

  // a flagged sample is always inside a run of at least one
  `FFD_ASSERT_IMPLY(a_run_nonzero, clk_i, rst_ni, out_valid_o, run_length_o != '0)

  // start plus run gives back the elapsed count without wrapping
  `FFD_ASSERT_IMPLY(a_start_fits, clk_i, rst_ni, out_valid_o, span_sum[ffd_pkg::OUT_WIDTH] == 1'b0)

endmodule

bind free_fall_detector ffd_checker u_ffd_checker (.*);

`default_nettype wire

### test/free_fall_detector_tb.sv
`timescale 1ns / 100ps
// self-checking bench for the free-fall detector: directed table and random runs
module free_fall_detector_tb;

  localparam int HALF_PERIOD   = 6;
  localparam int RESET_CYCLES  = 12;
  localparam int SETTLE_CYCLES = 4;
  localparam int SEG_ITEMS     = 165;
  localparam int MAX_REPORTS   = 30;
  localparam int TIMEOUT_NS    = 10_000_000;
  localparam int REG_SPARE     = 3;
  localparam int N_DIRECTED    = 37;

  localparam int DRAW_IN    = 0;
  localparam int DRAW_OUT   = 1;
  localparam int DRAW_NOISE = 2;

  typedef enum int {ROW_CFG, ROW_PREDICT, ROW_NONE, ROW_RECORD} row_kind_e;

  typedef struct packed {
    row_kind_e kind;
    int        reg_sel;
    int        value;
    int        x;
    int        y;
    int        z;
    int        fall;
    int        run;
    int        start;
  } step_row_t;

  logic clk_i      = 1'b0;
  logic rst_ni     = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [ffd_pkg::SAMPLE_WIDTH-1:0] accel_x_i = '0;
  logic signed [ffd_pkg::SAMPLE_WIDTH-1:0] accel_y_i = '0;
  logic signed [ffd_pkg::SAMPLE_WIDTH-1:0] accel_z_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [ffd_pkg::FALL_WIDTH-1:0] fall_index_o;
  logic [ffd_pkg::OUT_WIDTH-1:0]  run_length_o;
  logic [ffd_pkg::OUT_WIDTH-1:0]  start_sample_o;
  logic signed [ffd_pkg::SAMPLE_WIDTH-1:0] echo_x_o;
  logic signed [ffd_pkg::SAMPLE_WIDTH-1:0] echo_y_o;
  logic signed [ffd_pkg::SAMPLE_WIDTH-1:0] echo_z_o;
  logic psel    = 1'b0;
  logic penable = 1'b0;
  logic pwrite  = 1'b0;
  logic [ffd_pkg::APB_ADDR_W-1:0] paddr  = '0;
  logic [ffd_pkg::APB_DATA_W-1:0] pwdata = '0;
  logic [ffd_pkg::APB_DATA_W-1:0] prdata;
  logic pready;

  int unsigned      src_idle_pct   = 38;
  int unsigned      sink_stall_pct = 70;
  int               mismatches     = 0;
  ffd_pkg::record_t pending_records [$];

  // detector copy: configuration and counters
  logic signed [ffd_pkg::CFG_WIDTH-1:0] cfg_win_lo  = ffd_pkg::WINDOW_LOW_RST;
  logic signed [ffd_pkg::CFG_WIDTH-1:0] cfg_win_hi  = ffd_pkg::WINDOW_HIGH_RST;
  logic [ffd_pkg::MIN_WIDTH-1:0]        cfg_min_run = ffd_pkg::MIN_RUN_RST;
  logic [ffd_pkg::COUNT_WIDTH-1:0]      elapsed_cnt = '0;
  logic [ffd_pkg::COUNT_WIDTH-1:0]      run_cnt     = '0;
  logic [ffd_pkg::FALL_WIDTH-1:0]       fall_cnt    = '0;
  bit                                   prev_flagged = 1'b0;

  step_row_t directed_steps [N_DIRECTED] = '{
    '{ROW_NONE,    0, 0, -32768, 32767, 0, 0, 0, 0},
    '{ROW_NONE,    0, 0, 0, 0, 0, 0, 0, 0},
    '{ROW_NONE,    0, 0, 1638, -1638, 1638, 0, 0, 0},
    '{ROW_NONE,    0, 0, 1639, 0, 0, 0, 0, 0},
    '{ROW_CFG,     ffd_pkg::REG_MIN_RUN, 0, 0, 0, 0, 0, 0, 0},
    '{ROW_RECORD,  0, 0, -1638, 1638, 0, 1, 1, 4},
    '{ROW_PREDICT, 0, 0, 0, -1639, 0, 0, 0, 0},
    '{ROW_PREDICT, 0, 0, 0, 0, 1639, 0, 0, 0},
    '{ROW_PREDICT, 0, 0, 5, 5, 5, 0, 0, 0},
    '{ROW_PREDICT, 0, 0, -5, -5, -5, 0, 0, 0},
    '{ROW_CFG,     ffd_pkg::REG_MIN_RUN, 3, 0, 0, 0, 0, 0, 0},
    '{ROW_PREDICT, 0, 0, 0, 0, 0, 0, 0, 0},
    '{ROW_PREDICT, 0, 0, 32767, 0, 0, 0, 0, 0},
    '{ROW_PREDICT, 0, 0, 1, 1, 1, 0, 0, 0},
    '{ROW_PREDICT, 0, 0, 1, 1, 1, 0, 0, 0},
    '{ROW_PREDICT, 0, 0, 1, 1, 1, 0, 0, 0},
    '{ROW_CFG,     ffd_pkg::REG_WINDOW_LOW, -16384, 0, 0, 0, 0, 0, 0},
    '{ROW_CFG,     ffd_pkg::REG_WINDOW_HIGH, 16383, 0, 0, 0, 0, 0, 0},
    '{ROW_CFG,     ffd_pkg::REG_MIN_RUN, 1, 0, 0, 0, 0, 0, 0},
    '{ROW_RECORD,  0, 0, -16384, 16383, 0, 3, 4, 11},
    '{ROW_NONE,    0, 0, -16385, 0, 0, 0, 0, 0},
    '{ROW_NONE,    0, 0, 16384, 0, 0, 0, 0, 0},
    '{ROW_RECORD,  0, 0, 0, 0, 16383, 4, 1, 17},
    // crossed bounds: nothing can be in the window
    '{ROW_CFG,     ffd_pkg::REG_WINDOW_LOW, 100, 0, 0, 0, 0, 0, 0},
    '{ROW_CFG,     ffd_pkg::REG_WINDOW_HIGH, -100, 0, 0, 0, 0, 0, 0},
    '{ROW_NONE,    0, 0, 0, 0, 0, 0, 0, 0},
    '{ROW_NONE,    0, 0, 100, 100, 100, 0, 0, 0},
    '{ROW_NONE,    0, 0, -100, -100, -100, 0, 0, 0},
    '{ROW_CFG,     ffd_pkg::REG_WINDOW_LOW, 7, 0, 0, 0, 0, 0, 0},
    '{ROW_CFG,     ffd_pkg::REG_WINDOW_HIGH, 7, 0, 0, 0, 0, 0, 0},
    '{ROW_CFG,     ffd_pkg::REG_MIN_RUN, 65535, 0, 0, 0, 0, 0, 0},
    // unmapped address must not alias onto a real register
    '{ROW_CFG,     REG_SPARE, 0, 0, 0, 0, 0, 0, 0},
    '{ROW_PREDICT, 0, 0, 7, 7, 7, 0, 0, 0},
    '{ROW_CFG,     ffd_pkg::REG_MIN_RUN, 1, 0, 0, 0, 0, 0, 0},
    '{ROW_PREDICT, 0, 0, 7, 7, 7, 0, 0, 0},
    '{ROW_PREDICT, 0, 0, 7, 7, 8, 0, 0, 0},
    '{ROW_PREDICT, 0, 0, -32768, -32768, -32768, 0, 0, 0}
  };

  free_fall_detector dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .accel_x_i      (accel_x_i),
    .accel_y_i      (accel_y_i),
    .accel_z_i      (accel_z_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .fall_index_o   (fall_index_o),
    .run_length_o   (run_length_o),
    .start_sample_o (start_sample_o),
    .echo_x_o       (echo_x_o),
    .echo_y_o       (echo_y_o),
    .echo_z_o       (echo_z_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always begin
    #HALF_PERIOD clk_i = 1'b1;
    #HALF_PERIOD clk_i = 1'b0;
  end

  function automatic bit in_band(input logic signed [ffd_pkg::SAMPLE_WIDTH-1:0] a);
    return int'(a) >= int'(cfg_win_lo) && int'(a) <= int'(cfg_win_hi);
  endfunction

  // advances the counters by one sample, returns 1 when the sample is flagged
  function automatic bit step_detector(input ffd_pkg::sample_t s,
                                       output ffd_pkg::record_t rec);
    bit in_win;
    in_win = in_band(s.x) && in_band(s.y) && in_band(s.z);
    rec = '0;
    if (elapsed_cnt != '1) elapsed_cnt++;
    if (!in_win) begin
      run_cnt = '0;
    end else if (run_cnt != '1) begin
      run_cnt++;
    end
    if (!in_win || run_cnt < cfg_min_run) begin
      prev_flagged = 1'b0;
      return 1'b0;
    end
    if (!prev_flagged && fall_cnt != '1) fall_cnt++;
    prev_flagged = 1'b1;
    rec.fall_index   = fall_cnt;
    rec.run_length   = run_cnt;
    rec.start_sample = (elapsed_cnt >= run_cnt) ? elapsed_cnt - run_cnt : '0;
    rec.echo         = s;
    return 1'b1;
  endfunction

  function automatic logic signed [ffd_pkg::SAMPLE_WIDTH-1:0] pick_axis(input bit want_in);
    int lo;
    int hi;
    int v;
    lo = int'(cfg_win_lo);
    hi = int'(cfg_win_hi);
    if (lo > hi) return ffd_pkg::SAMPLE_WIDTH'($urandom);
    if (want_in) begin
      case ($urandom_range(7))
        0: v = lo;
        1: v = hi;
        default: v = lo + int'($urandom_range(hi - lo));
      endcase
    end else begin
      case ($urandom_range(7))
        0: v = lo - 1;
        1: v = hi + 1;
        2, 3, 4: v = -32768 + int'($urandom_range(lo + 32767));
        default: v = hi + 1 + int'($urandom_range(32766 - hi));
      endcase
    end
    return ffd_pkg::SAMPLE_WIDTH'(v);
  endfunction

  // out samples push one axis out of the window, sometimes more
  function automatic ffd_pkg::sample_t draw_sample(input int kind);
    logic signed [ffd_pkg::SAMPLE_WIDTH-1:0] ax [3];
    int odd_axis;
    odd_axis = $urandom_range(2);
    for (int a = 0; a < 3; a++) begin
      if (kind == DRAW_NOISE) begin
        ax[a] = ffd_pkg::SAMPLE_WIDTH'($urandom);
      end else begin
        ax[a] = pick_axis(kind == DRAW_IN || (a != odd_axis && $urandom_range(3) != 0));
      end
    end
    return {ax[0], ax[1], ax[2]};
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] expected_val);
    mismatches++;
    // keep the log short when something breaks badly
    if (mismatches <= MAX_REPORTS) begin
      $display("mismatch %s: got 0x%0h expected 0x%0h", what, got, expected_val);
    end
  endtask

  task automatic push_sample(input ffd_pkg::sample_t s, input row_kind_e how = ROW_PREDICT,
                             input ffd_pkg::record_t typed = '0);
    ffd_pkg::record_t rec;
    bit               flagged;
    @(negedge clk_i);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      {accel_x_i, accel_y_i, accel_z_i} <= 48'({$urandom, $urandom});
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    accel_x_i  <= s.x;
    accel_y_i  <= s.y;
    accel_z_i  <= s.z;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
    flagged = step_detector(s, rec);
    if (how == ROW_RECORD) begin
      pending_records = {pending_records, typed};
    end else if (how == ROW_PREDICT && flagged) begin
      pending_records = {pending_records, rec};
    end
  endtask

  task automatic write_reg(input int idx, input int value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ffd_pkg::APB_ADDR_W'(idx * 4);
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (pready !== 1'b1) @(posedge clk_i);
    case (idx)
      ffd_pkg::REG_WINDOW_LOW:  cfg_win_lo  = value[ffd_pkg::CFG_WIDTH-1:0];
      ffd_pkg::REG_WINDOW_HIGH: cfg_win_hi  = value[ffd_pkg::CFG_WIDTH-1:0];
      ffd_pkg::REG_MIN_RUN:     cfg_min_run = value[ffd_pkg::MIN_WIDTH-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // idle the input, wait for every record, then let unflagged samples drain
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_records.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic random_setting(input bit keep_open, input int min_run);
    int lo;
    int hi;
    lo = int'($urandom_range(32767)) - 16384;
    hi = lo + int'($urandom_range(3000));
    if (hi > 16383) hi = 16383;
    if (!keep_open) begin
      case ($urandom_range(5))
        0: begin
          lo = -16384;
          hi = 16383;
        end
        1: begin
          hi = int'($urandom_range(32766)) - 16384;
          lo = hi + 1 + int'($urandom_range(16382 - hi));
        end
        default: ;
      endcase
    end
    write_reg(ffd_pkg::REG_WINDOW_LOW, lo);
    write_reg(ffd_pkg::REG_WINDOW_HIGH, hi);
    write_reg(ffd_pkg::REG_MIN_RUN, min_run);
  endtask

  initial begin
    forever begin
      @(negedge clk_i);
      out_stall_i <= ($urandom_range(99) < sink_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    ffd_pkg::record_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_records.size() == 0) begin
        report_mismatch("record with nothing pending, fall_index", fall_index_o, 0);
      end else begin
        want = pending_records.pop_front();
        if (fall_index_o !== want.fall_index)
          report_mismatch("fall_index", fall_index_o, want.fall_index);
        if (run_length_o !== want.run_length)
          report_mismatch("run_length", run_length_o, want.run_length);
        if (start_sample_o !== want.start_sample)
          report_mismatch("start_sample", start_sample_o, want.start_sample);
        if (echo_x_o !== want.echo.x) report_mismatch("echo_x", echo_x_o, want.echo.x);
        if (echo_y_o !== want.echo.y) report_mismatch("echo_y", echo_y_o, want.echo.y);
        if (echo_z_o !== want.echo.z) report_mismatch("echo_z", echo_z_o, want.echo.z);
      end
    end
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    ffd_pkg::sample_t smp;
    ffd_pkg::record_t typed_rec;
    int               roll;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_steps[i]) begin
      if (directed_steps[i].kind == ROW_CFG) begin
        settle();
        write_reg(directed_steps[i].reg_sel, directed_steps[i].value);
      end else begin
        smp = {ffd_pkg::SAMPLE_WIDTH'(directed_steps[i].x),
               ffd_pkg::SAMPLE_WIDTH'(directed_steps[i].y),
               ffd_pkg::SAMPLE_WIDTH'(directed_steps[i].z)};
        typed_rec.fall_index   = ffd_pkg::FALL_WIDTH'(directed_steps[i].fall);
        typed_rec.run_length   = directed_steps[i].run;
        typed_rec.start_sample = directed_steps[i].start;
        typed_rec.echo         = smp;
        push_sample(smp, directed_steps[i].kind, typed_rec);
      end
    end

    for (int mode = 0; mode < 3; mode++) begin
      for (int seg = 0; seg < 4; seg++) begin
        settle();
        case (mode)
          0: begin
            src_idle_pct   = 38;
            sink_stall_pct = 70;
          end
          1: begin
            src_idle_pct   = 70;
            sink_stall_pct = 38;
          end
          default: begin
            src_idle_pct   = 0;
            sink_stall_pct = 0;
          end
        endcase
        random_setting(1'b0, ($urandom_range(9) == 0) ? int'($urandom_range(40))
                                                      : int'($urandom_range(5)));
        repeat (SEG_ITEMS) begin
          roll = $urandom_range(99);
          push_sample(draw_sample(roll < 4 ? DRAW_NOISE : roll < 18 ? DRAW_OUT : DRAW_IN));
        end
      end
    end

    settle();
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
